/* rtl/core/armdec_pkg.sv */
package armdec_pkg;

	typedef enum logic [3:0] {
		KIND_BX       = 4'd0,
		KIND_B        = 4'd1,
		KIND_MUL      = 4'd2,
		KIND_MULL     = 4'd3,
		KIND_UNDEF    = 4'd4,
		KIND_SWP      = 4'd5,
		KIND_LDR_STR  = 4'd6,
		KIND_HALFWORD = 4'd7,
		KIND_LDM_STM  = 4'd8,
		KIND_PSR      = 4'd9,
		KIND_DATAPROC = 4'd10,
		KIND_SWI      = 4'd11,
		KIND_CP_XFER  = 4'd12,
		KIND_CP_OP    = 4'd13,
		KIND_CP_REG   = 4'd14
	} kind_t;

	localparam logic [31:0] BX_MASK    = 32'h0FFF_FFF0;
	localparam logic [31:0] BX_PAT     = 32'h012F_FF10;
	localparam logic [31:0] B_MASK     = 32'h0E00_0000;
	localparam logic [31:0] B_PAT      = 32'h0A00_0000;
	localparam logic [31:0] MUL_MASK   = 32'h0FC0_00F0;
	localparam logic [31:0] MUL_PAT    = 32'h0000_0090;
	localparam logic [31:0] MULL_MASK  = 32'h0F80_00F0;
	localparam logic [31:0] MULL_PAT   = 32'h0080_0090;
	localparam logic [31:0] UNDEF_MASK = 32'h0E00_0010;
	localparam logic [31:0] UNDEF_PAT  = 32'h0600_0010;
	localparam logic [31:0] SWP_MASK   = 32'h0FB0_0FF0;
	localparam logic [31:0] SWP_PAT    = 32'h0100_0090;
	localparam logic [31:0] LDR_MASK   = 32'h0C00_0000;
	localparam logic [31:0] LDR_PAT    = 32'h0400_0000;
	localparam logic [31:0] HALF_MASK  = 32'h0E00_0090;
	localparam logic [31:0] HALF_PAT   = 32'h0000_0090;
	localparam logic [31:0] LDM_MASK   = 32'h0E00_0000;
	localparam logic [31:0] LDM_PAT    = 32'h0800_0000;
	localparam logic [31:0] DP_MASK    = 32'h0C00_0000;
	localparam logic [31:0] DP_PAT     = 32'h0000_0000;
	localparam logic [31:0] SWI_MASK   = 32'h0F00_0000;
	localparam logic [31:0] SWI_PAT    = 32'h0F00_0000;
	localparam logic [31:0] CPX_MASK   = 32'h0E00_0000;
	localparam logic [31:0] CPX_PAT    = 32'h0C00_0000;
	localparam logic [31:0] CPO_MASK   = 32'h0F00_0010;
	localparam logic [31:0] CPO_PAT    = 32'h0E00_0000;
	localparam logic [31:0] CPR_MASK   = 32'h0F00_0010;
	localparam logic [31:0] CPR_PAT    = 32'h0E00_0010;

	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_CMN = 4'd11;

	localparam logic [3:0] PSR_MRS       = 4'd0;
	localparam logic [3:0] PSR_MSR       = 4'd1;
	localparam logic [3:0] PSR_MSR_FLAGS = 4'd2;

	localparam int unsigned TDATA_IN_W  = 32;
	localparam int unsigned TDATA_OUT_W = 80;

	typedef struct packed {
		logic [3:0]  condition;
		kind_t       kind;
		logic [3:0]  reg_base;
		logic [3:0]  reg_dest;
		logic [3:0]  reg_operand;
		logic [3:0]  reg_shift;
		logic [31:0] value;
		logic [3:0]  opcode;
		logic [1:0]  shift_op;
		logic [4:0]  shift_amount;
		logic [4:0]  transfer_flags;
		logic [7:0]  mode_flags;
	} dec_res_t;

endpackage

/* rtl/core/arm32_instruction_decoder.sv */
// arm32_instruction_decoder
// decodes one 32-bit arm-state instruction word per beat into its class,
// condition, register numbers, flags, opcode, shift and a 32-bit value.
// input channel s_*: s_tdata carries the instruction word.
// output channel m_*: m_tuser carries the class, m_tdata the other fields.
// a beat moves when tvalid and tready are both high.
// an accepted input beat passes through the input register, then decode
// logic into the result register, before it reaches the output.
// throughput: one beat per cycle while m_tready stays high; the input
// register takes a new word while a result still waits only if it is
// empty, since its word moves on only when the result register can.
// when m_tready is low the result holds and at most two words are held
// inside; s_tready then drops until the output drains.
// reset (arst_n low) empties both registers at once; nothing is kept
// between beats.
module arm32_instruction_decoder import armdec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,  // instruction[31:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// condition, reg_base, reg_dest, reg_operand, reg_shift, value, opcode,
	// shift_op, shift_amount, transfer_flags, mode_flags, zero pad
	output logic [TDATA_OUT_W-1:0] m_tdata,
	output logic [3:0]             m_tuser   // kind
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	dec_res_t    res_s2;
	dec_res_t    dec_res;
	logic        adv_s2;
	logic        adv_s1;

	armdec_logic u_logic (
		.instr (instr_s1),
		.res   (dec_res)
	);

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign adv_s1   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			instr_s1 <= s_tdata;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {4'd0,
		res_s2.mode_flags, res_s2.transfer_flags, res_s2.shift_amount,
		res_s2.shift_op, res_s2.opcode, res_s2.value, res_s2.reg_shift,
		res_s2.reg_operand, res_s2.reg_dest, res_s2.reg_base, res_s2.condition};

	// empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// a beat taken while the output stalls is not lost
	a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("stalled output beat dropped");

	// a beat in the input register reaches the output stage next cycle
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> m_tvalid)
		else $error("decoded beat not delivered");

	// only fifteen classes exist
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 4'd15))
		else $error("class code out of range");

	// bx reports only the condition and the target register
	a_bx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.kind == KIND_BX) |-> (res_s2.value == 32'd0 &&
		res_s2.mode_flags == 8'd0 && res_s2.transfer_flags == 5'd0))
		else $error("bx beat carries stray fields");

endmodule

/* rtl/core/armdec_rot.sv */
module armdec_rot import armdec_pkg::*; (
	input  logic [11:0] imm12,
	output logic [31:0] rotated
);

	logic [4:0]  amount;
	logic [31:0] base;
	logic [63:0] doubled;

	assign amount  = {imm12[11:8], 1'b0};
	assign base    = {24'd0, imm12[7:0]};
	assign doubled = {base, base} >> amount;
	assign rotated = doubled[31:0];

endmodule

/* rtl/core/armdec_logic.sv */
module armdec_logic import armdec_pkg::*; (
	input  logic [31:0] instr,
	output dec_res_t    res
);

	logic [31:0] rot_value;
	logic [3:0]  op;
	logic        set;
	logic        imm;
	logic [4:0]  xfer;

	armdec_rot u_rot (
		.imm12   (instr[11:0]),
		.rotated (rot_value)
	);

	assign op   = instr[24:21];
	assign set  = instr[20];
	assign imm  = instr[25];
	assign xfer = {1'b0, instr[24], instr[23], instr[21], instr[20]};

	always_comb begin
		res           = '0;
		res.condition = instr[31:28];
		res.kind      = KIND_UNDEF;
		if ((instr & BX_MASK) == BX_PAT) begin
			res.kind        = KIND_BX;
			res.reg_operand = instr[3:0];
		end else if ((instr & B_MASK) == B_PAT) begin
			res.kind          = KIND_B;
			res.value         = {{6{instr[23]}}, instr[23:0], 2'b00} + 32'd8;
			res.mode_flags[0] = instr[24];
		end else if ((instr & MUL_MASK) == MUL_PAT) begin
			res.kind          = KIND_MUL;
			res.reg_operand   = instr[3:0];
			res.reg_shift     = instr[11:8];
			res.reg_base      = instr[15:12];
			res.reg_dest      = instr[19:16];
			res.mode_flags[1] = instr[20];
			res.mode_flags[2] = instr[21];
		end else if ((instr & MULL_MASK) == MULL_PAT) begin
			res.kind          = KIND_MULL;
			res.reg_operand   = instr[3:0];
			res.reg_shift     = instr[11:8];
			res.reg_base      = instr[15:12];
			res.reg_dest      = instr[19:16];
			res.mode_flags[1] = instr[20];
			res.mode_flags[2] = instr[21];
			res.mode_flags[3] = ~instr[22];
		end else if ((instr & UNDEF_MASK) == UNDEF_PAT) begin
			res.kind = KIND_UNDEF;
		end else if ((instr & SWP_MASK) == SWP_PAT) begin
			res.kind              = KIND_SWP;
			res.reg_operand       = instr[3:0];
			res.reg_dest          = instr[15:12];
			res.reg_base          = instr[19:16];
			res.transfer_flags[4] = instr[22];
		end else if ((instr & LDR_MASK) == LDR_PAT) begin
			res.kind              = KIND_LDR_STR;
			res.reg_dest          = instr[15:12];
			res.reg_base          = instr[19:16];
			res.transfer_flags    = xfer;
			res.transfer_flags[4] = instr[22];
			if (imm) begin
				res.reg_operand  = instr[3:0];
				res.shift_op     = instr[6:5];
				res.shift_amount = instr[11:7];
			end else begin
				res.value         = {20'd0, instr[11:0]};
				res.mode_flags[4] = 1'b1;
			end
		end else if ((instr & HALF_MASK) == HALF_PAT) begin
			res.kind           = KIND_HALFWORD;
			res.reg_operand    = instr[3:0];
			res.value          = {24'd0, (instr[22] ? instr[11:8] : 4'd0), instr[3:0]};
			res.reg_dest       = instr[15:12];
			res.reg_base       = instr[19:16];
			res.transfer_flags = xfer;
			res.mode_flags[4]  = instr[22];
			res.mode_flags[5]  = instr[5];
			res.mode_flags[6]  = instr[6];
		end else if ((instr & LDM_MASK) == LDM_PAT) begin
			res.kind              = KIND_LDM_STM;
			res.value             = {16'd0, instr[15:0]};
			res.reg_base          = instr[19:16];
			res.transfer_flags    = xfer;
			res.transfer_flags[4] = instr[22];
		end else if ((instr & DP_MASK) == DP_PAT) begin
			if ((op == OP_TST || op == OP_CMP) && !set) begin
				res.kind          = KIND_PSR;
				res.opcode        = PSR_MRS;
				res.reg_dest      = instr[15:12];
				res.mode_flags[7] = instr[22];
			end else if ((op == OP_TEQ || op == OP_CMN) && !set) begin
				res.kind   = KIND_PSR;
				res.opcode = instr[16] ? PSR_MSR : PSR_MSR_FLAGS;
				if (imm) begin
					res.value = rot_value;
				end else begin
					res.value       = {28'd0, instr[3:0]};
					res.reg_operand = instr[3:0];
				end
				res.mode_flags[4] = imm;
				res.mode_flags[7] = instr[22];
			end else begin
				res.kind          = KIND_DATAPROC;
				res.opcode        = op;
				res.reg_dest      = instr[15:12];
				res.reg_base      = instr[19:16];
				res.mode_flags[1] = set;
				res.mode_flags[4] = imm;
				if (imm) begin
					res.value = rot_value;
				end else begin
					res.reg_operand = instr[3:0];
					res.shift_op    = instr[6:5];
					if (instr[4]) begin
						res.reg_shift     = instr[11:8];
						res.mode_flags[7] = 1'b1;
					end else begin
						res.shift_amount = instr[11:7];
					end
				end
			end
		end else if ((instr & SWI_MASK) == SWI_PAT) begin
			res.kind = KIND_SWI;
		end else if ((instr & CPX_MASK) == CPX_PAT) begin
			res.kind              = KIND_CP_XFER;
			res.value             = {24'd0, instr[7:0]};
			res.reg_shift         = instr[11:8];
			res.reg_dest          = instr[15:12];
			res.reg_base          = instr[19:16];
			res.transfer_flags    = xfer;
			res.transfer_flags[4] = instr[22];
		end else if ((instr & CPO_MASK) == CPO_PAT) begin
			res.kind        = KIND_CP_OP;
			res.reg_operand = instr[3:0];
			res.reg_shift   = instr[11:8];
			res.reg_dest    = instr[15:12];
			res.reg_base    = instr[19:16];
			res.opcode      = instr[23:20];
		end else if ((instr & CPR_MASK) == CPR_PAT) begin
			res.kind              = KIND_CP_REG;
			res.reg_operand       = instr[3:0];
			res.reg_shift         = instr[11:8];
			res.reg_dest          = instr[15:12];
			res.reg_base          = instr[19:16];
			res.transfer_flags[0] = instr[20];
			res.opcode            = {1'b0, instr[23:21]};
		end else begin
			res.kind = KIND_UNDEF;
		end
	end

endmodule

/* tb/arm32_instruction_decoder_chk.sv */
`timescale 1ns / 100ps

module arm32_instruction_decoder_chk import armdec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic [3:0]             m_tuser,
	output int                     fail_count,
	output int                     pending
);

	dec_res_t decode_q[$];

	function automatic dec_res_t decode_word(logic [31:0] w);
		dec_res_t r;
		logic [31:0] off;
		logic [31:0] imm8;
		logic [63:0] rot;
		logic [3:0] op;
		logic [3:0] xfer;
		r = '0;
		r.condition = w[31:28];
		off = {{8{w[23]}}, w[23:0]};
		imm8 = {24'd0, w[7:0]};
		rot = {imm8, imm8} >> {w[11:8], 1'b0};
		op = w[24:21];
		xfer = {w[24], w[23], w[21], w[20]};
		if ((w & BX_MASK) == BX_PAT) begin
			r.kind = KIND_BX;
			r.reg_operand = w[3:0];
		end else if ((w & B_MASK) == B_PAT) begin
			r.kind = KIND_B;
			r.value = (off << 2) + 32'd8;
			r.mode_flags[0] = w[24];
		end else if ((w & MUL_MASK) == MUL_PAT) begin
			r.kind = KIND_MUL;
			r.reg_operand = w[3:0];
			r.reg_shift = w[11:8];
			r.reg_base = w[15:12];
			r.reg_dest = w[19:16];
			r.mode_flags[1] = w[20];
			r.mode_flags[2] = w[21];
		end else if ((w & MULL_MASK) == MULL_PAT) begin
			r.kind = KIND_MULL;
			r.reg_operand = w[3:0];
			r.reg_shift = w[11:8];
			r.reg_base = w[15:12];
			r.reg_dest = w[19:16];
			r.mode_flags[1] = w[20];
			r.mode_flags[2] = w[21];
			r.mode_flags[3] = ~w[22];
		end else if ((w & UNDEF_MASK) == UNDEF_PAT) begin
			r.kind = KIND_UNDEF;
		end else if ((w & SWP_MASK) == SWP_PAT) begin
			r.kind = KIND_SWP;
			r.reg_operand = w[3:0];
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.transfer_flags[4] = w[22];
		end else if ((w & LDR_MASK) == LDR_PAT) begin
			r.kind = KIND_LDR_STR;
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.transfer_flags = {w[22], xfer};
			if (w[25]) begin
				r.reg_operand = w[3:0];
				r.shift_op = w[6:5];
				r.shift_amount = w[11:7];
			end else begin
				r.value = {20'd0, w[11:0]};
				r.mode_flags[4] = 1'b1;
			end
		end else if ((w & HALF_MASK) == HALF_PAT) begin
			r.kind = KIND_HALFWORD;
			r.reg_operand = w[3:0];
			r.value = {24'd0, (w[22] ? w[11:8] : 4'd0), w[3:0]};
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.transfer_flags = {1'b0, xfer};
			r.mode_flags[4] = w[22];
			r.mode_flags[5] = w[5];
			r.mode_flags[6] = w[6];
		end else if ((w & LDM_MASK) == LDM_PAT) begin
			r.kind = KIND_LDM_STM;
			r.value = {16'd0, w[15:0]};
			r.reg_base = w[19:16];
			r.transfer_flags = {w[22], xfer};
		end else if ((w & DP_MASK) == DP_PAT) begin
			if ((op == OP_TST || op == OP_CMP) && !w[20]) begin
				r.kind = KIND_PSR;
				r.opcode = PSR_MRS;
				r.reg_dest = w[15:12];
				r.mode_flags[7] = w[22];
			end else if ((op == OP_TEQ || op == OP_CMN) && !w[20]) begin
				r.kind = KIND_PSR;
				r.opcode = w[16] ? PSR_MSR : PSR_MSR_FLAGS;
				if (w[25]) begin
					r.value = rot[31:0];
				end else begin
					r.value = {28'd0, w[3:0]};
					r.reg_operand = w[3:0];
				end
				r.mode_flags[4] = w[25];
				r.mode_flags[7] = w[22];
			end else begin
				r.kind = KIND_DATAPROC;
				r.opcode = op;
				r.reg_dest = w[15:12];
				r.reg_base = w[19:16];
				r.mode_flags[1] = w[20];
				r.mode_flags[4] = w[25];
				if (w[25]) begin
					r.value = rot[31:0];
				end else begin
					r.reg_operand = w[3:0];
					r.shift_op = w[6:5];
					if (w[4]) begin
						r.reg_shift = w[11:8];
						r.mode_flags[7] = 1'b1;
					end else begin
						r.shift_amount = w[11:7];
					end
				end
			end
		end else if ((w & SWI_MASK) == SWI_PAT) begin
			r.kind = KIND_SWI;
		end else if ((w & CPX_MASK) == CPX_PAT) begin
			r.kind = KIND_CP_XFER;
			r.value = {24'd0, w[7:0]};
			r.reg_shift = w[11:8];
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.transfer_flags = {w[22], xfer};
		end else if ((w & CPO_MASK) == CPO_PAT) begin
			r.kind = KIND_CP_OP;
			r.reg_operand = w[3:0];
			r.reg_shift = w[11:8];
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.opcode = w[23:20];
		end else if ((w & CPR_MASK) == CPR_PAT) begin
			r.kind = KIND_CP_REG;
			r.reg_operand = w[3:0];
			r.reg_shift = w[11:8];
			r.reg_dest = w[15:12];
			r.reg_base = w[19:16];
			r.transfer_flags[0] = w[20];
			r.opcode = {1'b0, w[23:21]};
		end else begin
			r.kind = KIND_UNDEF;
		end
		return r;
	endfunction

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		dec_res_t exp_res;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decode_q.size() == 0) begin
					$error("output beat with no instruction pending");
					fail_count++;
				end else begin
					exp_res = decode_q.pop_front();
					cmp_field("condition", exp_res.condition, m_tdata[3:0]);
					cmp_field("kind", exp_res.kind, m_tuser);
					cmp_field("reg_base", exp_res.reg_base, m_tdata[7:4]);
					cmp_field("reg_dest", exp_res.reg_dest, m_tdata[11:8]);
					cmp_field("reg_operand", exp_res.reg_operand, m_tdata[15:12]);
					cmp_field("reg_shift", exp_res.reg_shift, m_tdata[19:16]);
					cmp_field("value", exp_res.value, m_tdata[51:20]);
					cmp_field("opcode", exp_res.opcode, m_tdata[55:52]);
					cmp_field("shift_op", exp_res.shift_op, m_tdata[57:56]);
					cmp_field("shift_amount", exp_res.shift_amount, m_tdata[62:58]);
					cmp_field("transfer_flags", exp_res.transfer_flags, m_tdata[67:63]);
					cmp_field("mode_flags", exp_res.mode_flags, m_tdata[75:68]);
				end
			end
			if (s_tvalid && s_tready)
				decode_q.push_back(decode_word(s_tdata));
			pending = decode_q.size();
		end
	end

endmodule

/* tb/arm32_instruction_decoder_tb.sv */
`timescale 1ns / 100ps

module arm32_instruction_decoder_tb;
	import armdec_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [3:0]             m_tuser;

	int fail_count;
	int pending;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off = 1'b0;
	logic pressure_go = 1'b0;

	int idle_tbl[4] = '{68, 0, 9, 0};
	int stall_tbl[4] = '{0, 68, 9, 0};

	logic [31:0] directed_words[26] = '{
		32'hE12F_FF1E, 32'hEA00_0000, 32'hEBFF_FFFE, 32'h0A7F_FFFF,
		32'hE031_2394, 32'hE081_2394, 32'hE0F1_2394, 32'hE7F0_00F0,
		32'hE101_2093, 32'hE591_2FFF, 32'hE7B1_2FE3, 32'hE191_20B3,
		32'hE1D1_2FFF, 32'hE8BD_FFFF, 32'hE14F_0000, 32'hE129_F001,
		32'hE328_F4FF, 32'hE3B0_0FFF, 32'hE091_2312, 32'hE1A0_0FE1,
		32'hEF12_3456, 32'hEDF1_2345, 32'hEE12_3406, 32'hEE31_2F10,
		32'hFFFF_FFFF, 32'h0000_0000
	};

	arm32_instruction_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	arm32_instruction_decoder_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// long output stall while the sender keeps pushing
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (60) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int cls;
		w = $urandom;
		cls = $urandom_range(15);
		case (cls)
			KIND_BX:       w = (w & ~BX_MASK) | BX_PAT;
			KIND_B:        w = (w & ~B_MASK) | B_PAT;
			KIND_MUL:      w = (w & ~MUL_MASK) | MUL_PAT;
			KIND_MULL:     w = (w & ~MULL_MASK) | MULL_PAT;
			KIND_UNDEF:    w = (w & ~UNDEF_MASK) | UNDEF_PAT;
			KIND_SWP:      w = (w & ~SWP_MASK) | SWP_PAT;
			KIND_LDR_STR:  w = (w & ~LDR_MASK) | LDR_PAT;
			KIND_HALFWORD: w = (w & ~HALF_MASK) | HALF_PAT;
			KIND_LDM_STM:  w = (w & ~LDM_MASK) | LDM_PAT;
			KIND_PSR: begin
				w[27:26] = 2'b00;
				w[24:23] = 2'b10;
				w[20] = 1'b0;
			end
			KIND_DATAPROC: w = (w & ~DP_MASK) | DP_PAT;
			KIND_SWI:      w = (w & ~SWI_MASK) | SWI_PAT;
			KIND_CP_XFER:  w = (w & ~CPX_MASK) | CPX_PAT;
			KIND_CP_OP:    w = (w & ~CPO_MASK) | CPO_PAT;
			KIND_CP_REG:   w = (w & ~CPR_MASK) | CPR_PAT;
			default:       w = $urandom;
		endcase
		// near-miss encodings
		if ($urandom_range(7) == 0)
			w = w ^ (32'd1 << $urandom_range(31));
		return w;
	endfunction

	task automatic send_word(logic [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_words[i])
			send_word(directed_words[i]);
		pressure_go <= 1'b1;
		repeat (120) send_word(random_word());
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tbl[p];
			recv_stall_pct <= stall_tbl[p];
			repeat (200) send_word(random_word());
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/armdec_pkg.sv
rtl/core/armdec_rot.sv
rtl/core/armdec_logic.sv
rtl/core/arm32_instruction_decoder.sv
tb/arm32_instruction_decoder_chk.sv
tb/arm32_instruction_decoder_tb.sv
